/* sv/ptt_pkg.sv */
// shared types, widths and constants of the pan/tilt target tracker
package ptt_pkg;

  // frame size in pixels
  localparam int FRAME_W = 640;
  localparam int FRAME_H = 480;

  // field widths
  localparam int X_W    = 10;
  localparam int Y_W    = 9;
  localparam int LIM_W  = 10;
  localparam int GAIN_W = 16;
  localparam int STEP_W = 8;
  localparam int CELL_W = 4;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 16;

  // fixed point: positions Q10.8, gains Q0.16
  localparam int FRAC_W   = 8;
  localparam int POS_W    = LIM_W + FRAC_W;
  localparam int ERR_W    = 11;
  localparam int DIFF_W   = ERR_W + 1;
  localparam int PROD_P_W = GAIN_W + 1 + ERR_W;
  localparam int PROD_D_W = GAIN_W + 1 + DIFF_W;
  localparam int PD_W     = PROD_D_W + 1;
  localparam int SUM_W    = PD_W - FRAC_W + 2;

  // grid thresholds, compared against 3*x and 3*y
  localparam int TRIPLE_W = 13;
  localparam int HALF_W   = 12;

  // row and column codes
  localparam logic [1:0] BAND_LO  = 2'd0;
  localparam logic [1:0] BAND_MID = 2'd1;
  localparam logic [1:0] BAND_HI  = 2'd2;
  localparam logic [CELL_W-1:0] CELL_LAST = CELL_W'(8);

  // register indexes
  localparam logic [ADDR_W-1:0] REG_PROP_GAIN  = 3'd0;
  localparam logic [ADDR_W-1:0] REG_DERIV_GAIN = 3'd1;
  localparam logic [ADDR_W-1:0] REG_TILT_MIN   = 3'd2;
  localparam logic [ADDR_W-1:0] REG_TILT_MAX   = 3'd3;
  localparam logic [ADDR_W-1:0] REG_PAN_MIN    = 3'd4;
  localparam logic [ADDR_W-1:0] REG_PAN_MAX    = 3'd5;
  localparam logic [ADDR_W-1:0] REG_NUDGE_STEP = 3'd6;

  // register reset values
  localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 16'd131;
  localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 16'd39;
  localparam logic [LIM_W-1:0]  TILT_MIN_RST   = 10'd250;
  localparam logic [LIM_W-1:0]  TILT_MAX_RST   = 10'd480;
  localparam logic [LIM_W-1:0]  PAN_MIN_RST    = 10'd365;
  localparam logic [LIM_W-1:0]  PAN_MAX_RST    = 10'd700;
  localparam logic [STEP_W-1:0] NUDGE_STEP_RST = 8'd25;

  // position reset values, Q10.8
  localparam logic [POS_W-1:0] TILT_POS_RST = POS_W'(365 * 256);
  localparam logic [POS_W-1:0] PAN_POS_RST  = POS_W'(512 * 256);

  typedef struct packed {
    logic [X_W-1:0] ball_x;
    logic [Y_W-1:0] ball_y;
  } item_t;

  typedef struct packed {
    logic [LIM_W-1:0]  tilt_position;
    logic [LIM_W-1:0]  pan_position;
    logic [CELL_W-1:0] grid_cell;
  } result_t;

  // what one axis does for the current word
  typedef struct packed {
    logic centre;
    logic inc;
    logic dec;
  } axis_cmd_t;

endpackage

/* sv/ptt_axis.sv */
// one servo axis: position and previous error, nudge or pd update with clamp
module ptt_axis (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  ptt_pkg::axis_cmd_t         cmd,
  input  logic [ptt_pkg::ERR_W-1:0]  err,
  input  logic [ptt_pkg::GAIN_W-1:0] prop_gain,
  input  logic [ptt_pkg::GAIN_W-1:0] deriv_gain,
  input  logic [ptt_pkg::LIM_W-1:0]  lim_lo,
  input  logic [ptt_pkg::LIM_W-1:0]  lim_hi,
  input  logic [ptt_pkg::STEP_W-1:0] nudge_step,
  input  logic [ptt_pkg::POS_W-1:0]  pos_rst,
  output logic [ptt_pkg::LIM_W-1:0]  position_next
);
  import ptt_pkg::*;

  localparam logic signed [PD_W-1:0] PD_HALF = PD_W'(1 << (FRAC_W - 1));

  logic [POS_W-1:0]              pos;
  logic [POS_W-1:0]              pos_next;
  logic signed [ERR_W-1:0]       prev_err;
  logic signed [ERR_W-1:0]       prev_err_next;
  logic signed [ERR_W-1:0]       err_s;
  logic signed [DIFF_W-1:0]      diff;
  logic signed [PROD_P_W-1:0]    prod_p;
  logic signed [PROD_D_W-1:0]    prod_d;
  logic signed [PD_W-1:0]        pd_biased;
  logic signed [SUM_W-1:0]       term;
  logic signed [SUM_W-1:0]       delta;
  logic signed [SUM_W-1:0]       sum;
  logic signed [SUM_W-1:0]       q_lo;
  logic signed [SUM_W-1:0]       q_hi;

  assign err_s  = $signed(err);
  assign diff   = DIFF_W'(err_s) - DIFF_W'(prev_err);
  assign prod_p = $signed({1'b0, prop_gain}) * PROD_P_W'(err_s);
  assign prod_d = $signed({1'b0, deriv_gain}) * PROD_D_W'(diff);

  // round to Q.8, halves toward plus infinity: floor((s + 128) / 256)
  assign pd_biased = PD_W'(prod_p) + PD_W'(prod_d) + PD_HALF;
  assign term      = SUM_W'($signed(pd_biased[PD_W-1:FRAC_W]));

  assign q_lo = $signed(SUM_W'({lim_lo, FRAC_W'(0)}));
  assign q_hi = $signed(SUM_W'({lim_hi, FRAC_W'(0)}));

  always_comb begin
    if (cmd.centre) begin
      delta = term;
    end else if (cmd.inc) begin
      delta = $signed(SUM_W'({nudge_step, FRAC_W'(0)}));
    end else if (cmd.dec) begin
      delta = -$signed(SUM_W'({nudge_step, FRAC_W'(0)}));
    end else begin
      delta = '0;
    end
    sum = $signed(SUM_W'(pos)) + delta;

    // only a moved axis is clamped; max wins over min
    if (!(cmd.centre || cmd.inc || cmd.dec)) begin
      pos_next = pos;
    end else if (sum > q_hi) begin
      pos_next = q_hi[POS_W-1:0];
    end else if (sum < q_lo) begin
      pos_next = q_lo[POS_W-1:0];
    end else begin
      pos_next = sum[POS_W-1:0];
    end

    prev_err_next = cmd.centre ? err_s : '0;
  end

  assign position_next = pos_next[POS_W-1:FRAC_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= pos_rst;
      prev_err <= '0;
    end else if (en) begin
      pos      <= pos_next;
      prev_err <= prev_err_next;
    end
  end

endmodule

/* sv/pan_tilt_target_tracker.sv */
// pan/tilt target tracker top level: grid decode, config registers, result register
// a word taken on item is registered into result and shows there in the cycle after it is taken
// throughput: one word per cycle; item_ready is high whenever the result register is
// empty or is being taken in the same cycle
// reset (rst, synchronous): registers go to their defaults, tilt to 365.0, pan to
// 512.0, stored errors to zero, result register empties
module pan_tilt_target_tracker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_ready,
  input  ptt_pkg::item_t             item,
  output logic                       result_valid,
  input  logic                       result_ready,
  output ptt_pkg::result_t           result,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [ptt_pkg::ADDR_W-1:0] cfg_addr,
  input  logic [ptt_pkg::DATA_W-1:0] cfg_wdata
);
  import ptt_pkg::*;

  localparam logic [TRIPLE_W-1:0] X_LO_LIM = TRIPLE_W'(FRAME_W);
  localparam logic [TRIPLE_W-1:0] X_HI_LIM = TRIPLE_W'(2 * FRAME_W);
  localparam logic [TRIPLE_W-1:0] Y_LO_LIM = TRIPLE_W'(FRAME_H);
  localparam logic [TRIPLE_W-1:0] Y_HI_LIM = TRIPLE_W'(2 * FRAME_H);
  localparam logic [HALF_W-1:0]   X_HALF   = HALF_W'(FRAME_W / 2);
  localparam logic [HALF_W-1:0]   Y_HALF   = HALF_W'(FRAME_H / 2);

  logic [GAIN_W-1:0] prop_gain;
  logic [GAIN_W-1:0] deriv_gain;
  logic [LIM_W-1:0]  tilt_min;
  logic [LIM_W-1:0]  tilt_max;
  logic [LIM_W-1:0]  pan_min;
  logic [LIM_W-1:0]  pan_max;
  logic [STEP_W-1:0] nudge_step;

  logic                 accept;
  logic [TRIPLE_W-1:0]  x3;
  logic [TRIPLE_W-1:0]  y3;
  logic [1:0]           col;
  logic [1:0]           row;
  logic                 centre;
  logic signed [HALF_W-1:0] ex;
  logic signed [HALF_W-1:0] ey;
  axis_cmd_t            tilt_cmd;
  axis_cmd_t            pan_cmd;
  logic [LIM_W-1:0]     tilt_next;
  logic [LIM_W-1:0]     pan_next;
  result_t              result_next;

  assign cfg_ready  = 1'b1;
  assign item_ready = !result_valid || result_ready;
  assign accept     = item_valid && item_ready;

  // grid: compare 3*coord against the frame size to avoid dividing
  assign x3 = (TRIPLE_W'(item.ball_x) << 1) + TRIPLE_W'(item.ball_x);
  assign y3 = (TRIPLE_W'(item.ball_y) << 1) + TRIPLE_W'(item.ball_y);

  always_comb begin
    if (x3 <= X_LO_LIM) begin
      col = BAND_LO;
    end else if (x3 >= X_HI_LIM) begin
      col = BAND_HI;
    end else begin
      col = BAND_MID;
    end
    if (y3 <= Y_LO_LIM) begin
      row = BAND_LO;
    end else if (y3 >= Y_HI_LIM) begin
      row = BAND_HI;
    end else begin
      row = BAND_MID;
    end
  end

  assign centre = (row == BAND_MID) && (col == BAND_MID);

  assign ex = $signed(X_HALF) - $signed(HALF_W'(item.ball_x));
  assign ey = $signed(Y_HALF) - $signed(HALF_W'(item.ball_y));

  // x error drives tilt, y error drives pan; top row raises tilt, left column raises pan
  assign tilt_cmd.centre = centre;
  assign tilt_cmd.inc    = (row == BAND_LO);
  assign tilt_cmd.dec    = (row == BAND_HI);
  assign pan_cmd.centre  = centre;
  assign pan_cmd.inc     = (col == BAND_LO);
  assign pan_cmd.dec     = (col == BAND_HI);

  ptt_axis u_tilt (
    .clk          (clk),
    .rst          (rst),
    .en           (accept),
    .cmd          (tilt_cmd),
    .err          (ex[ERR_W-1:0]),
    .prop_gain    (prop_gain),
    .deriv_gain   (deriv_gain),
    .lim_lo       (tilt_min),
    .lim_hi       (tilt_max),
    .nudge_step   (nudge_step),
    .pos_rst      (TILT_POS_RST),
    .position_next(tilt_next)
  );

  ptt_axis u_pan (
    .clk          (clk),
    .rst          (rst),
    .en           (accept),
    .cmd          (pan_cmd),
    .err          (ey[ERR_W-1:0]),
    .prop_gain    (prop_gain),
    .deriv_gain   (deriv_gain),
    .lim_lo       (pan_min),
    .lim_hi       (pan_max),
    .nudge_step   (nudge_step),
    .pos_rst      (PAN_POS_RST),
    .position_next(pan_next)
  );

  assign result_next.tilt_position = tilt_next;
  assign result_next.pan_position  = pan_next;
  assign result_next.grid_cell     = (CELL_W'(row) << 1) + CELL_W'(row) + CELL_W'(col);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain  <= PROP_GAIN_RST;
      deriv_gain <= DERIV_GAIN_RST;
      tilt_min   <= TILT_MIN_RST;
      tilt_max   <= TILT_MAX_RST;
      pan_min    <= PAN_MIN_RST;
      pan_max    <= PAN_MAX_RST;
      nudge_step <= NUDGE_STEP_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_addr)
        REG_PROP_GAIN:  prop_gain  <= cfg_wdata[GAIN_W-1:0];
        REG_DERIV_GAIN: deriv_gain <= cfg_wdata[GAIN_W-1:0];
        REG_TILT_MIN:   tilt_min   <= cfg_wdata[LIM_W-1:0];
        REG_TILT_MAX:   tilt_max   <= cfg_wdata[LIM_W-1:0];
        REG_PAN_MIN:    pan_min    <= cfg_wdata[LIM_W-1:0];
        REG_PAN_MAX:    pan_max    <= cfg_wdata[LIM_W-1:0];
        REG_NUDGE_STEP: nudge_step <= cfg_wdata[STEP_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

/* sv/ptt_checker.sv */
// port-level checks on the pan/tilt target tracker, bound to the top level
module ptt_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       item_valid,
  input logic                       item_ready,
  input ptt_pkg::item_t             item,
  input logic                       result_valid,
  input logic                       result_ready,
  input ptt_pkg::result_t           result,
  input logic                       cfg_valid,
  input logic                       cfg_ready,
  input logic [ptt_pkg::ADDR_W-1:0] cfg_addr,
  input logic [ptt_pkg::DATA_W-1:0] cfg_wdata
);
  import ptt_pkg::*;

  // a stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

  // every accepted word yields a result on the next cycle
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> result_valid)
    else $error("accepted word produced no result");

  // an empty result register never blocks input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> item_ready)
    else $error("input stalled with empty result register");

  // cell index stays within the grid
  a_cell_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.grid_cell <= CELL_LAST)
    else $error("grid cell out of range");

endmodule

bind pan_tilt_target_tracker ptt_checker u_ptt_checker (
  .clk         (clk),
  .rst         (rst),
  .item_valid  (item_valid),
  .item_ready  (item_ready),
  .item        (item),
  .result_valid(result_valid),
  .result_ready(result_ready),
  .result      (result),
  .cfg_valid   (cfg_valid),
  .cfg_ready   (cfg_ready),
  .cfg_addr    (cfg_addr),
  .cfg_wdata   (cfg_wdata)
);
